// File: rtl/svs_pkg.sv
// ----------------------------------------------------------------------------
// svs_pkg: shared definitions for the summing value stack
// action and status codes, field widths and the shift control struct
// ----------------------------------------------------------------------------
package svs_pkg;

    localparam int STACK_DEPTH_DEF = 16;

    localparam int VAL_W     = 8;
    localparam int AMT_W     = 12;
    localparam int CNT_IN_W  = 5;
    localparam int SUM_OUT_W = 12;
    localparam int CNT_OUT_W = 5;

    localparam int SAT_SUM = 4095;
    localparam int SAT_CNT = 31;

    localparam logic [1:0] ACT_PUSH        = 2'd0;
    localparam logic [1:0] ACT_TAKE_AMOUNT = 2'd1;
    localparam logic [1:0] ACT_TAKE_COUNT  = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_OVERFLOW = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;
    localparam logic [1:0] ST_SHORT    = 2'd3;

    typedef struct packed {
        logic push;
        logic pop;
    } t_shift_ctl;

endpackage

// File: rtl/svs_cell.sv
// ----------------------------------------------------------------------------
// svs_cell: one stack slot
// shifts toward the bottom on push and toward the top on pop
// ----------------------------------------------------------------------------
module svs_cell (
    input  logic                     i_clk,
    input  svs_pkg::t_shift_ctl      i_ctl,
    input  logic [svs_pkg::VAL_W-1:0] i_from_up,
    input  logic [svs_pkg::VAL_W-1:0] i_from_down,
    output logic [svs_pkg::VAL_W-1:0] o_value
);

    logic [svs_pkg::VAL_W-1:0] r_value;

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_value <= i_from_up;
        end else if (i_ctl.pop) begin
            r_value <= i_from_down;
        end
    end

    assign o_value = r_value;

endmodule

// File: rtl/svs_ctrl.sv
// ----------------------------------------------------------------------------
// svs_ctrl: command sequencer of the summing value stack
// checks each command, pops one top entry a cycle and holds the result
// ----------------------------------------------------------------------------
module svs_ctrl #(
    parameter int STACK_DEPTH = svs_pkg::STACK_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [1:0]                    i_action,
    input  logic [svs_pkg::VAL_W-1:0]     i_push_value,
    input  logic [svs_pkg::AMT_W-1:0]     i_target_amount,
    input  logic [svs_pkg::CNT_IN_W-1:0]  i_take_count,
    input  logic [svs_pkg::VAL_W-1:0]     i_top_value,
    output svs_pkg::t_shift_ctl           o_ctl,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [1:0]                    o_status,
    output logic [svs_pkg::SUM_OUT_W-1:0] o_popped_sum,
    output logic [svs_pkg::CNT_OUT_W-1:0] o_popped_count,
    output logic [svs_pkg::SUM_OUT_W-1:0] o_total_after,
    output logic [svs_pkg::CNT_OUT_W-1:0] o_depth_after
);

    localparam int DEP_W = $clog2(STACK_DEPTH + 1);
    localparam int TOT_W = $clog2(STACK_DEPTH * 255 + 1);
    localparam int SUM_W = (TOT_W > svs_pkg::AMT_W) ? TOT_W : svs_pkg::AMT_W;
    localparam int CNT_W = (DEP_W > svs_pkg::CNT_IN_W) ? DEP_W : svs_pkg::CNT_IN_W;

    typedef enum logic [1:0] {S_IDLE, S_POP, S_DONE} t_state;

    t_state                       r_state, n_state;
    logic [1:0]                   r_status, n_status;
    logic [SUM_W-1:0]             r_sum, n_sum;
    logic [SUM_W-1:0]             r_total, n_total;
    logic [CNT_W-1:0]             r_n, n_n;
    logic [DEP_W-1:0]             r_depth, n_depth;
    logic                         r_by_amount, n_by_amount;
    logic [svs_pkg::AMT_W-1:0]    r_target, n_target;
    logic [svs_pkg::CNT_IN_W-1:0] r_count, n_count;

    logic accept;
    logic pop_now;
    logic full;

    assign o_in_stall = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_DONE);
    assign accept = i_in_valid && !o_in_stall;
    assign full = (r_depth == DEP_W'(STACK_DEPTH));

    // amount mode keeps popping until the sum reaches the target
    assign pop_now = (r_state == S_POP) &&
                     (r_by_amount ? (r_sum < SUM_W'(r_target))
                                  : (r_n < CNT_W'(r_count)));

    always_comb begin
        n_state     = r_state;
        n_status    = r_status;
        n_sum       = r_sum;
        n_total     = r_total;
        n_n         = r_n;
        n_depth     = r_depth;
        n_by_amount = r_by_amount;
        n_target    = r_target;
        n_count     = r_count;
        o_ctl.push  = 1'b0;
        o_ctl.pop   = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_status    = svs_pkg::ST_OK;
                    n_sum       = '0;
                    n_n         = '0;
                    n_state     = S_DONE;
                    n_target    = i_target_amount;
                    n_count     = i_take_count;
                    n_by_amount = (i_action == svs_pkg::ACT_TAKE_AMOUNT);
                    case (i_action)
                        svs_pkg::ACT_PUSH: begin
                            if (full) begin
                                n_status = svs_pkg::ST_OVERFLOW;
                            end else begin
                                o_ctl.push = 1'b1;
                                n_depth    = r_depth + 1'b1;
                                n_total    = r_total + SUM_W'(i_push_value);
                            end
                        end
                        svs_pkg::ACT_TAKE_AMOUNT: begin
                            if (r_depth == '0) begin
                                n_status = svs_pkg::ST_EMPTY;
                            end else if (r_total < SUM_W'(i_target_amount)) begin
                                n_status = svs_pkg::ST_SHORT;
                            end else begin
                                n_state = S_POP;
                            end
                        end
                        svs_pkg::ACT_TAKE_COUNT: begin
                            if (r_depth == '0) begin
                                n_status = svs_pkg::ST_EMPTY;
                            end else if (CNT_W'(r_depth) < CNT_W'(i_take_count)) begin
                                n_status = svs_pkg::ST_SHORT;
                            end else begin
                                n_state = S_POP;
                            end
                        end
                        default: begin
                            n_status = svs_pkg::ST_OK;
                        end
                    endcase
                end
            end
            S_POP: begin
                if (pop_now) begin
                    o_ctl.pop = 1'b1;
                    n_sum     = r_sum + SUM_W'(i_top_value);
                    n_total   = r_total - SUM_W'(i_top_value);
                    n_depth   = r_depth - 1'b1;
                    n_n       = r_n + 1'b1;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_depth  <= '0;
            r_total  <= '0;
            r_status <= svs_pkg::ST_OK;
            r_sum    <= '0;
            r_n      <= '0;
        end else begin
            r_state  <= n_state;
            r_depth  <= n_depth;
            r_total  <= n_total;
            r_status <= n_status;
            r_sum    <= n_sum;
            r_n      <= n_n;
        end
        r_by_amount <= n_by_amount;
        r_target    <= n_target;
        r_count     <= n_count;
    end

    // wide totals and counts saturate in the result fields
    assign o_status       = r_status;
    assign o_popped_sum   = (r_sum > SUM_W'(svs_pkg::SAT_SUM)) ?
                            svs_pkg::SUM_OUT_W'(svs_pkg::SAT_SUM) :
                            r_sum[svs_pkg::SUM_OUT_W-1:0];
    assign o_total_after  = (r_total > SUM_W'(svs_pkg::SAT_SUM)) ?
                            svs_pkg::SUM_OUT_W'(svs_pkg::SAT_SUM) :
                            r_total[svs_pkg::SUM_OUT_W-1:0];
    assign o_popped_count = (r_n > CNT_W'(svs_pkg::SAT_CNT)) ?
                            svs_pkg::CNT_OUT_W'(svs_pkg::SAT_CNT) :
                            r_n[svs_pkg::CNT_OUT_W-1:0];
    assign o_depth_after  = (CNT_W'(r_depth) > CNT_W'(svs_pkg::SAT_CNT)) ?
                            svs_pkg::CNT_OUT_W'(svs_pkg::SAT_CNT) :
                            svs_pkg::CNT_OUT_W'(CNT_W'(r_depth));

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.pop |-> (r_depth != '0))
        else $error("pop with empty stack");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.push |-> !full)
        else $error("push into full stack");

    a_empty_zero_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_depth == '0) |-> (r_total == '0))
        else $error("empty stack with nonzero total");

    a_push_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.push |=> (r_depth == DEP_W'($past(r_depth) + 1'b1)))
        else $error("push did not grow depth");

endmodule

// File: rtl/summing_value_stack_top.sv
// ----------------------------------------------------------------------------
// summing_value_stack_top: bounded stack with running total and sum pops
// a row of shifting slots with the top at slot 0, driven by one sequencer
// ----------------------------------------------------------------------------
// usage
//   input channel: i_in_valid / o_in_stall carry one command beat (action,
//   push value, target amount, take count). output channel: o_out_valid /
//   i_out_stall carry one result beat per command (status, popped sum,
//   popped count, total after, depth after).
// command sequence
//   push, no-op and rejected takes: result valid in the cycle after the beat.
//   a take that goes on to remove k entries (k may be zero) pops one top
//   entry per cycle through the slot row, then sees the stop and turns the
//   result valid, with k at most STACK_DEPTH.
// one command is in flight at a time; o_in_stall is high after the accepted
// beat until its result beat is taken. while the receiver stalls, the
// result holds and no new command is taken.
// reset clears depth and total at once; slot contents are not cleared and
// are never read before they are written.
// ----------------------------------------------------------------------------
module summing_value_stack_top #(
    parameter int STACK_DEPTH = svs_pkg::STACK_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [1:0]                    i_action,
    input  logic [svs_pkg::VAL_W-1:0]     i_push_value,
    input  logic [svs_pkg::AMT_W-1:0]     i_target_amount,
    input  logic [svs_pkg::CNT_IN_W-1:0]  i_take_count,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [1:0]                    o_status,
    output logic [svs_pkg::SUM_OUT_W-1:0] o_popped_sum,
    output logic [svs_pkg::CNT_OUT_W-1:0] o_popped_count,
    output logic [svs_pkg::SUM_OUT_W-1:0] o_total_after,
    output logic [svs_pkg::CNT_OUT_W-1:0] o_depth_after
);

    svs_pkg::t_shift_ctl       ctl;
    logic [svs_pkg::VAL_W-1:0] slot_value [STACK_DEPTH];

    svs_ctrl #(
        .STACK_DEPTH(STACK_DEPTH)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_action       (i_action),
        .i_push_value   (i_push_value),
        .i_target_amount(i_target_amount),
        .i_take_count   (i_take_count),
        .i_top_value    (slot_value[0]),
        .o_ctl          (ctl),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_popped_sum   (o_popped_sum),
        .o_popped_count (o_popped_count),
        .o_total_after  (o_total_after),
        .o_depth_after  (o_depth_after)
    );

    for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_slot
        logic [svs_pkg::VAL_W-1:0] from_up;
        logic [svs_pkg::VAL_W-1:0] from_down;

        if (g == 0) begin : g_top
            assign from_up = i_push_value;
        end else begin : g_mid
            assign from_up = slot_value[g-1];
        end

        // bottom slot refills with zero on pop
        if (g == STACK_DEPTH - 1) begin : g_bottom
            assign from_down = '0;
        end else begin : g_upper
            assign from_down = slot_value[g+1];
        end

        svs_cell u_cell (
            .i_clk      (i_clk),
            .i_ctl      (ctl),
            .i_from_up  (from_up),
            .i_from_down(from_down),
            .o_value    (slot_value[g])
        );
    end

endmodule

// File: bench/summing_value_stack_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// summing_value_stack_top_test: self-checking bench for the summing stack
// a queue-fed driver sends push, take-by-amount, take-by-count and no-op beats
// with random gaps; a monitor with random stalls checks every result beat
// against an in-bench model of the stack, depth and running total
// ----------------------------------------------------------------------------
module summing_value_stack_top_test;

    localparam int          DEPTH          = svs_pkg::STACK_DEPTH_DEF;
    localparam logic [1:0]  ACT_NOP        = 2'd3;
    localparam int          RANDOM_CMDS    = 400;
    localparam int          QUIET_TAIL     = 60;
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          END_SETTLE     = 40;
    localparam int          MAX_REPORTS    = 10;

    typedef struct packed {
        logic [1:0]                   action;
        logic [svs_pkg::VAL_W-1:0]    value;
        logic [svs_pkg::AMT_W-1:0]    amount;
        logic [svs_pkg::CNT_IN_W-1:0] count;
        logic                         drain;
    } t_cmd;

    typedef struct packed {
        logic [1:0]                    status;
        logic [svs_pkg::SUM_OUT_W-1:0] popped_sum;
        logic [svs_pkg::CNT_OUT_W-1:0] popped_count;
        logic [svs_pkg::SUM_OUT_W-1:0] total_after;
        logic [svs_pkg::CNT_OUT_W-1:0] depth_after;
    } t_result;

    typedef struct packed {
        logic [DEPTH-1:0][svs_pkg::VAL_W-1:0] cells;
        logic [7:0]                           depth;
        logic [15:0]                          total;
    } t_stack_state;

    logic                          i_clk           = 1'b0;
    logic                          i_rst_n         = 1'b0;
    logic                          i_in_valid      = 1'b0;
    logic                          o_in_stall;
    logic [1:0]                    i_action        = svs_pkg::ACT_PUSH;
    logic [svs_pkg::VAL_W-1:0]     i_push_value    = '0;
    logic [svs_pkg::AMT_W-1:0]     i_target_amount = '0;
    logic [svs_pkg::CNT_IN_W-1:0]  i_take_count    = '0;
    logic                          o_out_valid;
    logic                          i_out_stall     = 1'b0;
    logic [1:0]                    o_status;
    logic [svs_pkg::SUM_OUT_W-1:0] o_popped_sum;
    logic [svs_pkg::CNT_OUT_W-1:0] o_popped_count;
    logic [svs_pkg::SUM_OUT_W-1:0] o_total_after;
    logic [svs_pkg::CNT_OUT_W-1:0] o_depth_after;

    t_cmd         pending_cmds[$];
    t_result      awaited_results[$];
    t_stack_state gen_stack;
    t_stack_state pred_stack;
    t_cmd         cur_cmd;

    int total_cmds     = 0;
    int cmds_accepted  = 0;
    int results_seen   = 0;
    int fail_cnt       = 0;
    int gap_left       = 0;
    int stall_left     = 0;
    int idle_cycles    = 0;
    int deepest        = 0;
    int status_seen[4] = '{0, 0, 0, 0};
    bit in_storm       = 1'b1;
    bit out_storm      = 1'b1;

    summing_value_stack_top #(
        .STACK_DEPTH (DEPTH)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_action        (i_action),
        .i_push_value    (i_push_value),
        .i_target_amount (i_target_amount),
        .i_take_count    (i_take_count),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_status        (o_status),
        .o_popped_sum    (o_popped_sum),
        .o_popped_count  (o_popped_count),
        .o_total_after   (o_total_after),
        .o_depth_after   (o_depth_after)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // applies one command to a stack image and returns the result beat it yields
    function automatic t_result stack_apply(inout t_stack_state st, input t_cmd c);
        t_result r;
        int      dep;
        int      tot;
        int      sum;
        int      n;
        r   = '0;
        dep = int'(st.depth);
        tot = int'(st.total);
        sum = 0;
        n   = 0;
        r.status = svs_pkg::ST_OK;
        case (c.action)
            svs_pkg::ACT_PUSH: begin
                if (dep >= DEPTH) begin
                    r.status = svs_pkg::ST_OVERFLOW;
                end else begin
                    st.cells[dep] = c.value;
                    dep++;
                    tot += int'(c.value);
                end
            end
            svs_pkg::ACT_TAKE_AMOUNT: begin
                if (dep == 0) begin
                    r.status = svs_pkg::ST_EMPTY;
                end else if (tot < int'(c.amount)) begin
                    r.status = svs_pkg::ST_SHORT;
                end else begin
                    while (sum < int'(c.amount) && dep > 0) begin
                        dep--;
                        sum += int'(st.cells[dep]);
                        tot -= int'(st.cells[dep]);
                        n++;
                    end
                end
            end
            svs_pkg::ACT_TAKE_COUNT: begin
                if (dep == 0) begin
                    r.status = svs_pkg::ST_EMPTY;
                end else if (dep < int'(c.count)) begin
                    r.status = svs_pkg::ST_SHORT;
                end else begin
                    while (n < int'(c.count)) begin
                        dep--;
                        sum += int'(st.cells[dep]);
                        tot -= int'(st.cells[dep]);
                        n++;
                    end
                end
            end
            default: begin
                // unused code: report state, change nothing
            end
        endcase
        st.depth       = 8'(dep);
        st.total       = 16'(tot);
        r.popped_sum   = svs_pkg::SUM_OUT_W'((sum > svs_pkg::SAT_SUM) ? svs_pkg::SAT_SUM : sum);
        r.popped_count = svs_pkg::CNT_OUT_W'((n > svs_pkg::SAT_CNT) ? svs_pkg::SAT_CNT : n);
        r.total_after  = svs_pkg::SUM_OUT_W'((tot > svs_pkg::SAT_SUM) ? svs_pkg::SAT_SUM : tot);
        r.depth_after  = svs_pkg::CNT_OUT_W'((dep > svs_pkg::SAT_CNT) ? svs_pkg::SAT_CNT : dep);
        return r;
    endfunction

    // queues one command and advances the generator's image of the stack
    task automatic queue_cmd(input logic [1:0] action,
                             input logic [svs_pkg::VAL_W-1:0] value,
                             input logic [svs_pkg::AMT_W-1:0] amount,
                             input logic [svs_pkg::CNT_IN_W-1:0] count,
                             input logic drain);
        t_cmd c;
        c.action = action;
        c.value  = value;
        c.amount = amount;
        c.count  = count;
        c.drain  = drain;
        void'(stack_apply(gen_stack, c));
        pending_cmds.push_back(c);
    endtask

    // driver: presents queued beats, holds them while stalled, inserts gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            gap_left = 0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                awaited_results.push_back(stack_apply(pred_stack, cur_cmd));
                cmds_accepted++;
            end
            if (i_in_valid && o_in_stall) begin
                // beat stays put until taken
            end else if (gap_left != 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (pending_cmds.size() != 0 &&
                         !(pending_cmds[0].drain && awaited_results.size() != 0)) begin
                cur_cmd = pending_cmds.pop_front();
                i_action        <= cur_cmd.action;
                i_push_value    <= cur_cmd.value;
                i_target_amount <= cur_cmd.amount;
                i_take_count    <= cur_cmd.count;
                i_in_valid      <= 1'b1;
                if (in_storm && cmds_accepted + QUIET_TAIL < total_cmds &&
                    $urandom_range(0, 2) == 0)
                    gap_left = $urandom_range(1, 4);
            end else begin
                i_in_valid <= 1'b0;
            end
            if ($urandom_range(0, 49) == 0)
                in_storm = !in_storm;
        end
    end

    // monitor: checks each taken result beat, drives random stall bursts
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                got.status       = o_status;
                got.popped_sum   = o_popped_sum;
                got.popped_count = o_popped_count;
                got.total_after  = o_total_after;
                got.depth_after  = o_depth_after;
                results_seen++;
                if (awaited_results.size() == 0) begin
                    fail_cnt++;
                    if (fail_cnt <= MAX_REPORTS)
                        $display("result beat %0d arrived with nothing outstanding",
                                 results_seen);
                end else begin
                    want = awaited_results.pop_front();
                    if (got !== want) begin
                        fail_cnt++;
                        if (fail_cnt <= MAX_REPORTS)
                            $display("result beat %0d mismatch: expected st %0d sum %0d ",
                                     results_seen, want.status, want.popped_sum,
                                     "cnt %0d tot %0d dep %0d, ",
                                     want.popped_count, want.total_after,
                                     want.depth_after,
                                     "got st %0d sum %0d cnt %0d tot %0d dep %0d",
                                     got.status, got.popped_sum,
                                     got.popped_count, got.total_after, got.depth_after);
                    end
                    status_seen[want.status]++;
                    if (int'(want.depth_after) > deepest)
                        deepest = int'(want.depth_after);
                end
            end
            if (stall_left != 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else if (out_storm && cmds_accepted + QUIET_TAIL < total_cmds &&
                         $urandom_range(0, 3) == 0) begin
                stall_left = $urandom_range(1, 4) - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
            if ($urandom_range(0, 39) == 0)
                out_storm = !out_storm;
        end
    end

    // watchdog on cycles with no beat on either channel
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog expired: %0d of %0d commands taken, %0d results pending",
                         cmds_accepted, total_cmds, awaited_results.size());
                $display("summing_value_stack_top regression: fail");
                $finish;
            end
        end
    end

    initial begin
        int                           n_rand;
        int                           phase;
        int                           phase_left;
        int                           pick;
        int                           push_pct;
        logic [1:0]                   act;
        logic [svs_pkg::VAL_W-1:0]    val;
        logic [svs_pkg::AMT_W-1:0]    amt;
        logic [svs_pkg::CNT_IN_W-1:0] cnt;

        gen_stack  = '0;
        pred_stack = '0;
        phase      = 2;
        phase_left = 0;
        n_rand     = 0;
        // filler for fields the directed commands do not use
        val        = svs_pkg::VAL_W'($urandom);
        amt        = svs_pkg::AMT_W'($urandom);
        cnt        = svs_pkg::CNT_IN_W'($urandom);

        // empty-stack takes, including zero amount and out-of-range count, and a no-op
        queue_cmd(svs_pkg::ACT_TAKE_AMOUNT, val, 12'd0, cnt, 1'b0);
        queue_cmd(svs_pkg::ACT_TAKE_COUNT, val, amt, 5'd31, 1'b0);
        queue_cmd(ACT_NOP, val, amt, cnt, 1'b0);
        // fill to the top with the largest value
        for (int i = 0; i < DEPTH; i++)
            queue_cmd(svs_pkg::ACT_PUSH, 8'hFF, amt, cnt, 1'b0);
        queue_cmd(svs_pkg::ACT_PUSH, 8'h00, amt, cnt, 1'b0);
        queue_cmd(ACT_NOP, val, amt, cnt, 1'b0);
        queue_cmd(svs_pkg::ACT_TAKE_COUNT, val, amt, 5'd17, 1'b0);
        queue_cmd(svs_pkg::ACT_TAKE_AMOUNT, val, 12'hFFF, cnt, 1'b0);
        // exact total empties the whole stack
        queue_cmd(svs_pkg::ACT_TAKE_AMOUNT, val, 12'd4080, cnt, 1'b0);
        queue_cmd(svs_pkg::ACT_PUSH, 8'h00, amt, cnt, 1'b0);
        queue_cmd(svs_pkg::ACT_TAKE_AMOUNT, val, 12'd0, cnt, 1'b0);
        queue_cmd(svs_pkg::ACT_TAKE_COUNT, val, amt, 5'd0, 1'b0);
        queue_cmd(svs_pkg::ACT_TAKE_COUNT, val, amt, 5'd1, 1'b0);

        // random part: fill, drain and mixed phases steered by the stack image
        while (n_rand < RANDOM_CMDS) begin
            if (phase_left == 0) begin
                phase      = $urandom_range(0, 2);
                phase_left = $urandom_range(8, 40);
            end
            phase_left--;
            push_pct = (phase == 0) ? 75 : (phase == 1) ? 25 : 50;
            pick = $urandom_range(0, 99);
            val  = svs_pkg::VAL_W'($urandom);
            amt  = svs_pkg::AMT_W'($urandom);
            cnt  = svs_pkg::CNT_IN_W'($urandom);
            if ($urandom_range(0, 24) == 0) begin
                act = ACT_NOP;
            end else if (pick < push_pct) begin
                act  = svs_pkg::ACT_PUSH;
                pick = $urandom_range(0, 99);
                if (pick < 15)
                    val = 8'hFF;
                else if (pick < 30)
                    val = 8'h00;
            end else if ($urandom_range(0, 1) == 0) begin
                act  = svs_pkg::ACT_TAKE_AMOUNT;
                pick = $urandom_range(0, 99);
                if (pick < 80)
                    amt = svs_pkg::AMT_W'($urandom_range(0, gen_stack.total));
                else if (pick < 90)
                    amt = svs_pkg::AMT_W'($urandom_range(gen_stack.total, 4095));
            end else begin
                act = svs_pkg::ACT_TAKE_COUNT;
                if ($urandom_range(0, 99) < 80)
                    cnt = svs_pkg::CNT_IN_W'($urandom_range(0, gen_stack.depth));
            end
            queue_cmd(act, val, amt, cnt, (n_rand % 100 == 0) && act != ACT_NOP);
            if (act != ACT_NOP)
                n_rand++;
        end
        total_cmds = pending_cmds.size();

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_cmds.size() != 0 || i_in_valid || awaited_results.size() != 0)
            @(posedge i_clk);
        repeat (END_SETTLE) @(posedge i_clk);
        if (awaited_results.size() != 0)
            fail_cnt++;

        $display("%0d commands checked: %0d ok, %0d overflow, %0d empty, %0d short",
                 results_seen, status_seen[svs_pkg::ST_OK], status_seen[svs_pkg::ST_OVERFLOW],
                 status_seen[svs_pkg::ST_EMPTY], status_seen[svs_pkg::ST_SHORT]);
        $display("deepest stack reached %0d of %0d, %0d failures", deepest, DEPTH, fail_cnt);
        if (fail_cnt == 0)
            $display("summing_value_stack_top regression: pass");
        else
            $display("summing_value_stack_top regression: fail");
        $finish;
    end

endmodule

// File: sim.f
rtl/svs_pkg.sv
rtl/svs_cell.sv
rtl/svs_ctrl.sv
rtl/summing_value_stack_top.sv
bench/summing_value_stack_top_test.sv
